>>> src/stch_pkg.sv
// Package for the settable twelve-hour clock.
// Holds the mode codes, the request and result types and the time-field helpers.
// Has no dependencies of its own.
`default_nettype none

package stch_pkg;

  typedef enum logic [2:0] {
    MODE_INIT       = 3'd0,
    MODE_RUN        = 3'd1,
    MODE_SET_SECOND = 3'd2,
    MODE_SET_MINUTE = 3'd3,
    MODE_SET_HOUR   = 3'd4,
    MODE_COMMIT     = 3'd5
  } mode_t;

  localparam logic [15:0] TICKS_RESET = 16'd1000;
  localparam logic [5:0]  SEC_TOP     = 6'd59;
  localparam logic [5:0]  MIN_TOP     = 6'd59;
  localparam logic [5:0]  HOUR_TOP    = 6'd11;
  localparam logic [5:0]  SEC_RESET   = 6'd10;
  localparam logic [5:0]  MIN_RESET   = 6'd4;
  localparam logic [3:0]  HOUR_RESET  = 4'd5;
  // Multiply by 13 and shift by 6 gives the quotient by five for values below 64.
  localparam logic [3:0]  DIV5_MUL    = 4'd13;

  typedef struct packed {
    logic base_tick;
    logic mode_pressed;
    logic up_pressed;
    logic down_pressed;
    logic save_pressed;
  } req_t;

  typedef struct packed {
    mode_t      clock_mode;
    logic [5:0] shown_second;
    logic [5:0] shown_minute;
    logic [3:0] shown_hour;
    logic [3:0] second_led;
    logic [3:0] minute_led;
  } result_t;

  function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] top);
    return (v >= top) ? 6'd0 : v + 6'd1;
  endfunction

  function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] top);
    return (v == 6'd0 || v > top) ? top : v - 6'd1;
  endfunction

  function automatic logic [5:0] edit_field(input logic [5:0] v, input logic [5:0] top,
                                            input logic up, input logic down);
    logic [5:0] r;
    r = v;
    if (up && !down) begin
      r = wrap_up(v, top);
    end else if (down && !up) begin
      r = wrap_down(v, top);
    end
    return r;
  endfunction

  function automatic logic [3:0] div5(input logic [5:0] v);
    logic [9:0] p;
    p = 10'(v) * 10'(DIV5_MUL);
    return p[9:6];
  endfunction

endpackage

`default_nettype wire

>>> src/stch_if.sv
// Channel interfaces of the settable twelve-hour clock: button request,
// displayed result and tick-count configuration. Uses no package.
`default_nettype none

interface stch_in_if;
  logic valid;
  logic ready;
  logic base_tick;
  logic mode_pressed;
  logic up_pressed;
  logic down_pressed;
  logic save_pressed;
  modport source (output valid, base_tick, mode_pressed, up_pressed, down_pressed,
                  save_pressed, input ready);
  modport sink (input valid, base_tick, mode_pressed, up_pressed, down_pressed,
                save_pressed, output ready);
endinterface

interface stch_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] clock_mode;
  logic [5:0] shown_second;
  logic [5:0] shown_minute;
  logic [3:0] shown_hour;
  logic [3:0] second_led;
  logic [3:0] minute_led;
  modport source (output valid, clock_mode, shown_second, shown_minute, shown_hour,
                  second_led, minute_led, input ready);
  modport sink (input valid, clock_mode, shown_second, shown_minute, shown_hour,
                second_led, minute_led, output ready);
endinterface

interface stch_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] ticks_per_second;
  modport source (output valid, ticks_per_second, input ready);
  modport sink (input valid, ticks_per_second, output ready);
endinterface

`default_nettype wire

>>> src/stch_core.sv
// Clock state and its one-pass update: prescaler, mode sequencing, run and edit times.
// Depends on stch_pkg for the mode codes, request and result types and field helpers.
`default_nettype none

module stch_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire stch_pkg::req_t   req,
  input  wire logic [15:0]      ticks_per_second,
  output stch_pkg::result_t     result
);

  stch_pkg::mode_t mode_r, mode_nxt;
  logic [5:0]  run_sec_r, run_sec_nxt, run_min_r, run_min_nxt;
  logic [3:0]  run_hour_r, run_hour_nxt;
  logic [5:0]  edit_sec_r, edit_sec_nxt, edit_min_r, edit_min_nxt;
  logic [3:0]  edit_hour_r, edit_hour_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        due_r, due_nxt;

  logic        tick_eff;
  logic [16:0] cnt_inc;
  logic        expire;
  logic        show_edit;
  logic [5:0]  shown_sec, shown_min;
  logic [3:0]  shown_hour;

  always_comb begin
    tick_eff = req.base_tick && !due_r;
    cnt_inc  = {1'b0, cnt_r} + 17'd1;
    expire   = tick_eff && (cnt_inc >= {1'b0, ticks_per_second});

    due_nxt = due_r | expire;
    cnt_nxt = cnt_r;
    if (expire) begin
      cnt_nxt = 16'd0;
    end else if (tick_eff) begin
      cnt_nxt = cnt_inc[15:0];
    end

    mode_nxt      = mode_r;
    run_sec_nxt   = run_sec_r;
    run_min_nxt   = run_min_r;
    run_hour_nxt  = run_hour_r;
    edit_sec_nxt  = edit_sec_r;
    edit_min_nxt  = edit_min_r;
    edit_hour_nxt = edit_hour_r;
    show_edit     = 1'b0;

    unique case (mode_r)
      stch_pkg::MODE_RUN: begin
        if (due_nxt) begin
          due_nxt = 1'b0;
          cnt_nxt = 16'd0;
          if (run_sec_r >= stch_pkg::SEC_TOP) begin
            run_sec_nxt = 6'd0;
            if (run_min_r >= stch_pkg::MIN_TOP) begin
              run_min_nxt  = 6'd0;
              run_hour_nxt = 4'(stch_pkg::wrap_up(6'(run_hour_r), stch_pkg::HOUR_TOP));
            end else begin
              run_min_nxt = run_min_r + 6'd1;
            end
          end else begin
            run_sec_nxt = run_sec_r + 6'd1;
          end
        end
        if (req.mode_pressed) begin
          edit_sec_nxt  = run_sec_nxt;
          edit_min_nxt  = run_min_nxt;
          edit_hour_nxt = run_hour_nxt;
          mode_nxt      = stch_pkg::MODE_SET_SECOND;
        end
      end
      stch_pkg::MODE_SET_SECOND: begin
        show_edit    = 1'b1;
        edit_sec_nxt = stch_pkg::edit_field(edit_sec_r, stch_pkg::SEC_TOP,
                                            req.up_pressed, req.down_pressed);
        if (req.mode_pressed) begin
          mode_nxt = stch_pkg::MODE_SET_MINUTE;
        end
        if (req.save_pressed) begin
          mode_nxt = stch_pkg::MODE_COMMIT;
        end
      end
      stch_pkg::MODE_SET_MINUTE: begin
        show_edit    = 1'b1;
        edit_min_nxt = stch_pkg::edit_field(edit_min_r, stch_pkg::MIN_TOP,
                                            req.up_pressed, req.down_pressed);
        if (req.mode_pressed) begin
          mode_nxt = stch_pkg::MODE_SET_HOUR;
        end
        if (req.save_pressed) begin
          mode_nxt = stch_pkg::MODE_COMMIT;
        end
      end
      stch_pkg::MODE_SET_HOUR: begin
        show_edit     = 1'b1;
        edit_hour_nxt = 4'(stch_pkg::edit_field(6'(edit_hour_r), stch_pkg::HOUR_TOP,
                                                req.up_pressed, req.down_pressed));
        if (req.mode_pressed) begin
          due_nxt  = 1'b0;
          cnt_nxt  = 16'd0;
          mode_nxt = stch_pkg::MODE_RUN;
        end
        if (req.save_pressed) begin
          mode_nxt = stch_pkg::MODE_COMMIT;
        end
      end
      stch_pkg::MODE_COMMIT: begin
        run_sec_nxt  = edit_sec_r;
        run_min_nxt  = edit_min_r;
        run_hour_nxt = edit_hour_r;
        due_nxt      = 1'b0;
        cnt_nxt      = 16'd0;
        mode_nxt     = stch_pkg::MODE_RUN;
      end
      default: begin
        due_nxt  = 1'b0;
        cnt_nxt  = 16'd0;
        mode_nxt = stch_pkg::MODE_RUN;
      end
    endcase

    shown_sec  = show_edit ? edit_sec_nxt  : run_sec_nxt;
    shown_min  = show_edit ? edit_min_nxt  : run_min_nxt;
    shown_hour = show_edit ? edit_hour_nxt : run_hour_nxt;

    result.clock_mode   = mode_nxt;
    result.shown_second = shown_sec;
    result.shown_minute = shown_min;
    result.shown_hour   = shown_hour;
    result.second_led   = stch_pkg::div5(shown_sec);
    result.minute_led   = stch_pkg::div5(shown_min);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= stch_pkg::MODE_INIT;
      run_sec_r   <= stch_pkg::SEC_RESET;
      run_min_r   <= stch_pkg::MIN_RESET;
      run_hour_r  <= stch_pkg::HOUR_RESET;
      edit_sec_r  <= 6'd0;
      edit_min_r  <= 6'd0;
      edit_hour_r <= 4'd0;
      cnt_r       <= 16'd0;
      due_r       <= 1'b0;
    end else if (adv) begin
      mode_r      <= mode_nxt;
      run_sec_r   <= run_sec_nxt;
      run_min_r   <= run_min_nxt;
      run_hour_r  <= run_hour_nxt;
      edit_sec_r  <= edit_sec_nxt;
      edit_min_r  <= edit_min_nxt;
      edit_hour_r <= edit_hour_nxt;
      cnt_r       <= cnt_nxt;
      due_r       <= due_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/settable_twelve_hour_clock.sv
// Settable twelve-hour clock, top level: request register, clock core, result register.
// A request accepted into the request register passes through the core into the result register, then is offered.
// Throughput is one request per cycle while the output is not stalled; the single-pass core sets that figure.
// Synchronous active-low reset restores 5:04:10 in init mode and 1000 ticks per second.
// Depends on stch_pkg, the interfaces in stch_if and stch_core.
`default_nettype none

module settable_twelve_hour_clock (
  input  wire logic clk,
  input  wire logic rst_n,
  stch_in_if.sink   in_ch,
  stch_out_if.source out_ch,
  stch_cfg_if.sink  cfg_ch
);

  logic              in_vld_r;
  stch_pkg::req_t    req_r;
  logic              out_vld_r;
  stch_pkg::result_t res_r;
  stch_pkg::result_t res_nxt;
  logic [15:0]       tps_r;
  logic              adv;

  assign adv          = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= stch_pkg::TICKS_RESET;
    end else if (cfg_ch.valid) begin
      tps_r <= cfg_ch.ticks_per_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      req_r.base_tick    <= in_ch.base_tick;
      req_r.mode_pressed <= in_ch.mode_pressed;
      req_r.up_pressed   <= in_ch.up_pressed;
      req_r.down_pressed <= in_ch.down_pressed;
      req_r.save_pressed <= in_ch.save_pressed;
    end
  end

  stch_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .req              (req_r),
    .ticks_per_second (tps_r),
    .result           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ch.ready) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.clock_mode   = 3'(res_r.clock_mode);
  assign out_ch.shown_second = res_r.shown_second;
  assign out_ch.shown_minute = res_r.shown_minute;
  assign out_ch.shown_hour   = res_r.shown_hour;
  assign out_ch.second_led   = res_r.second_led;
  assign out_ch.minute_led   = res_r.minute_led;

endmodule

`default_nettype wire
